>>> design/hsl2rgb_pkg.sv
// hsl2rgb_pkg: shared types and constants for the hsl to rgb converter
// no dependencies; imported by the converter modules
`timescale 1ns / 1ps

package hsl2rgb_pkg;

    // cycles from an accepted start to the result strobe
    localparam int LATENCY = 5;

    // segment of the piecewise-linear hue ramp
    typedef enum logic [1:0] {
        SEG_RISE = 2'd0,
        SEG_HIGH = 2'd1,
        SEG_FALL = 2'd2,
        SEG_LOW  = 2'd3
    } t_seg;

endpackage

>>> design/hsl2rgb_qp.sv
// hsl2rgb_qp: two pipeline stages forming q, p and the ramp span q - p
// depends on nothing outside this file; fed by the input stage of the top level
`timescale 1ns / 1ps

module hsl2rgb_qp #(
    parameter int FRAC_BITS = 15
) (
    input  logic                 i_clk,
    input  logic [FRAC_BITS:0]   i_sat,
    input  logic [FRAC_BITS:0]   i_light,
    output logic [FRAC_BITS:0]   o_q,
    output logic [FRAC_BITS:0]   o_p,
    output logic [FRAC_BITS:0]   o_d
);

    localparam int W  = FRAC_BITS + 1;
    localparam int MW = 2 * FRAC_BITS + 3;
    localparam logic [W-1:0] ONE  = W'(1) << FRAC_BITS;
    localparam logic [W-1:0] HALF = W'(1) << (FRAC_BITS - 1);

    logic          w_lo;
    logic [W:0]    w_mop;
    logic [MW-1:0] w_mul;
    logic [W-1:0]  n_prod;
    logic [W-1:0]  r_prod;
    logic [W-1:0]  r_l;
    logic [W-1:0]  r_s;
    logic          r_lo;

    logic [W:0]    w_qraw;
    logic [W-1:0]  w_q;
    logic [W:0]    w_2l;
    logic [W-1:0]  w_p;
    logic [W-1:0]  r_q;
    logic [W-1:0]  r_p;
    logic [W-1:0]  r_d;

    // product stage: l*(1+s) below one half, l*s otherwise
    always_comb begin
        w_lo   = (i_light < HALF);
        w_mop  = w_lo ? ((W+1)'(ONE) + (W+1)'(i_sat)) : (W+1)'(i_sat);
        w_mul  = MW'(i_light) * MW'(w_mop);
        n_prod = w_mul[FRAC_BITS + W - 1:FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_l    <= i_light;
        r_s    <= i_sat;
        r_lo   <= w_lo;
    end

    // q, p and span, each held to 0..one
    always_comb begin
        w_qraw = r_lo ? (W+1)'(r_prod) : ((W+1)'(r_l) + (W+1)'(r_s) - (W+1)'(r_prod));
        w_q    = (w_qraw > (W+1)'(ONE)) ? ONE : w_qraw[W-1:0];
        w_2l   = (W+1)'(r_l) << 1;
        if (w_2l < (W+1)'(w_q)) begin
            w_p = '0;
        end else if ((w_2l - (W+1)'(w_q)) > (W+1)'(ONE)) begin
            w_p = ONE;
        end else begin
            w_p = W'(w_2l - (W+1)'(w_q));
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= w_q;
        r_p <= w_p;
        r_d <= (w_q > w_p) ? (w_q - w_p) : '0;
    end

    assign o_q = r_q;
    assign o_p = r_p;
    assign o_d = r_d;

endmodule

>>> design/hsl2rgb_chan.sv
// hsl2rgb_chan: one color channel, hue ramp segment select, scaling and clamp
// depends on hsl2rgb_pkg; takes q, p, span from hsl2rgb_qp two stages after the hue
`timescale 1ns / 1ps

module hsl2rgb_chan #(
    parameter int FRAC_BITS = 15
) (
    input  logic                   i_clk,
    input  logic [FRAC_BITS-1:0]   i_t,
    input  logic [FRAC_BITS:0]     i_q,
    input  logic [FRAC_BITS:0]     i_p,
    input  logic [FRAC_BITS:0]     i_d,
    output logic [FRAC_BITS:0]     o_val
);

    import hsl2rgb_pkg::*;

    localparam int W   = FRAC_BITS + 1;
    localparam int FW  = FRAC_BITS + 2;
    localparam int MW  = 2 * FRAC_BITS + 3;
    localparam int PW  = FRAC_BITS + 3;
    localparam int ONE_I = 1 << FRAC_BITS;
    localparam logic [W-1:0] ONE = W'(ONE_I);
    localparam logic [FRAC_BITS-1:0] SIXTH      = FRAC_BITS'((ONE_I + 3) / 6);
    localparam logic [FRAC_BITS-1:0] HALF       = FRAC_BITS'(ONE_I / 2);
    localparam logic [FRAC_BITS-1:0] TWO_THIRDS = FRAC_BITS'((2 * ONE_I + 1) / 3);

    t_seg          n_seg;
    logic [FW-1:0] n_fac;
    t_seg          r2_seg;
    logic [FW-1:0] r2_fac;
    t_seg          r3_seg;
    logic [FW-1:0] r3_fac;

    logic [MW-1:0] w_mul;
    logic [PW-1:0] r4_prod;
    logic [W-1:0]  r4_p;
    logic [W-1:0]  r4_q;
    t_seg          r4_seg;

    logic [PW:0]   w_sum;
    logic [W-1:0]  n_val;
    logic [W-1:0]  r5_val;

    // segment and slope factor from the hue position
    always_comb begin
        priority if (i_t < SIXTH) begin
            n_seg = SEG_RISE;
            n_fac = FW'((FW+1)'(i_t) * (FW+1)'(6));
        end else if (i_t < HALF) begin
            n_seg = SEG_HIGH;
            n_fac = '0;
        end else if (i_t < TWO_THIRDS) begin
            n_seg = SEG_FALL;
            n_fac = FW'((FW+1)'(TWO_THIRDS - i_t) * (FW+1)'(6));
        end else begin
            n_seg = SEG_LOW;
            n_fac = '0;
        end
    end

    // segment stage, then one delay to meet q and p
    always_ff @(posedge i_clk) begin
        r2_seg <= n_seg;
        r2_fac <= n_fac;
        r3_seg <= r2_seg;
        r3_fac <= r2_fac;
    end

    // span times slope factor
    assign w_mul = MW'(i_d) * MW'(r3_fac);

    always_ff @(posedge i_clk) begin
        r4_prod <= w_mul[FRAC_BITS + PW - 1:FRAC_BITS];
        r4_p    <= i_p;
        r4_q    <= i_q;
        r4_seg  <= r3_seg;
    end

    // pick the ramp value and hold it to 0..one
    always_comb begin
        w_sum = (PW+1)'(r4_p) + (PW+1)'(r4_prod);
        unique case (r4_seg)
            SEG_RISE, SEG_FALL: n_val = (w_sum > (PW+1)'(ONE)) ? ONE : w_sum[W-1:0];
            SEG_HIGH:           n_val = r4_q;
            SEG_LOW:            n_val = r4_p;
            default:            n_val = r4_p;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r5_val <= n_val;
    end

    assign o_val = r5_val;

endmodule

>>> design/hsl_to_rgb_converter.sv
// hsl_to_rgb_converter: the start transfer reaches o_valid through the stages listed below
// throughput one color per cycle; busy is always low, a start is taken every cycle
// the receiver cannot stall: each result shows for one cycle under o_valid
// stages: input clamp and hue offsets, q/p product, q/p and span, channel product, clamp
// reset (i_rst_n, synchronous, active low) clears only the valid pipeline
// depends on hsl2rgb_pkg, hsl2rgb_qp and hsl2rgb_chan
`timescale 1ns / 1ps

module hsl_to_rgb_converter #(
    parameter int FRAC_BITS = 15
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [FRAC_BITS-1:0] i_hue,
    input  logic [FRAC_BITS:0]   i_saturation,
    input  logic [FRAC_BITS:0]   i_lightness,
    output logic                 o_valid,
    output logic [FRAC_BITS:0]   o_red,
    output logic [FRAC_BITS:0]   o_green,
    output logic [FRAC_BITS:0]   o_blue
);

    import hsl2rgb_pkg::*;

    localparam int W = FRAC_BITS + 1;
    localparam int ONE_I = 1 << FRAC_BITS;
    localparam logic [W-1:0] ONE = W'(ONE_I);
    localparam logic [FRAC_BITS-1:0] THIRD = FRAC_BITS'((ONE_I + 1) / 3);

    logic [LATENCY-1:0]   r_vld;
    logic [FRAC_BITS-1:0] r_th;
    logic [FRAC_BITS-1:0] r_tr;
    logic [FRAC_BITS-1:0] r_tb;
    logic [W-1:0]         r_s;
    logic [W-1:0]         r_l;
    logic [W-1:0]         w_q;
    logic [W-1:0]         w_p;
    logic [W-1:0]         w_d;

    // the pipeline never stalls
    assign busy = 1'b0;

    // valid bits travel alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LATENCY-2:0], start};
        end
    end

    // input stage: clamp to one, hue offsets wrap in one turn
    always_ff @(posedge i_clk) begin
        r_s  <= (i_saturation > ONE) ? ONE : i_saturation;
        r_l  <= (i_lightness > ONE) ? ONE : i_lightness;
        r_th <= i_hue;
        r_tr <= i_hue + THIRD;
        r_tb <= i_hue - THIRD;
    end

    hsl2rgb_qp #(.FRAC_BITS(FRAC_BITS)) u_qp (
        .i_clk   (i_clk),
        .i_sat   (r_s),
        .i_light (r_l),
        .o_q     (w_q),
        .o_p     (w_p),
        .o_d     (w_d)
    );

    hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_red (
        .i_clk (i_clk),
        .i_t   (r_tr),
        .i_q   (w_q),
        .i_p   (w_p),
        .i_d   (w_d),
        .o_val (o_red)
    );

    hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_green (
        .i_clk (i_clk),
        .i_t   (r_th),
        .i_q   (w_q),
        .i_p   (w_p),
        .i_d   (w_d),
        .o_val (o_green)
    );

    hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_blue (
        .i_clk (i_clk),
        .i_t   (r_tb),
        .i_q   (w_q),
        .i_p   (w_p),
        .i_d   (w_d),
        .o_val (o_blue)
    );

    assign o_valid = r_vld[LATENCY-1];

`ifndef SYNTH
    // every start transfer comes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##5 o_valid)
        else $error("result strobe missing after start");

    // no result strobe without a matching start
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 5))
        else $error("result strobe without start");

    // zero saturation comes out gray
    a_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && (i_saturation == '0)) |-> ##5 ((o_red == o_green) && (o_green == o_blue)))
        else $error("zero saturation not gray");

    // channels stay within 0..one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_red <= ONE) && (o_green <= ONE) && (o_blue <= ONE)))
        else $error("channel above full scale");
`endif

endmodule
